>>> sv/pff_pkg.sv
`timescale 1ns / 1ps

package pff_pkg;

   // field widths
   localparam int CHAR_W = 8;
   localparam int ARG_W  = 64;
   localparam int LEN_W  = 16;

   // binary to decimal conversion: 64 binary bits give at most 20 bcd digits
   localparam int BCD_DIGITS = 20;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int DAB_CNT_W  = $clog2(ARG_W);

   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // character codes
   localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_LONG    = 8'h6C;
   localparam logic [CHAR_W-1:0] CH_X_UPPER = 8'h58;
   localparam logic [CHAR_W-1:0] CH_CHAR    = 8'h63;
   localparam logic [CHAR_W-1:0] CH_DEC_D   = 8'h64;
   localparam logic [CHAR_W-1:0] CH_DEC_I   = 8'h69;
   localparam logic [CHAR_W-1:0] CH_OCT     = 8'h6F;
   localparam logic [CHAR_W-1:0] CH_PTR     = 8'h70;
   localparam logic [CHAR_W-1:0] CH_UNS     = 8'h75;
   localparam logic [CHAR_W-1:0] CH_X_LOWER = 8'h78;

   localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   // outcome of decoding one format byte
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_ERROR = 2'd2,
      KIND_NUM   = 2'd3
   } kind_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic decode;
      logic dabble;
      logic gen;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     is_dec;
      logic     dabble_last;
      logic     gen_last;
      logic     emit_last;
      logic     out_free;
   } stat_type;

endpackage

>>> sv/pff_channels.sv
`timescale 1ns / 1ps

// format byte channel
interface pff_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  fmt_char;
   logic [63:0] arg_value;
   logic        fmt_last;

   modport source (output valid, output fmt_char, output arg_value, output fmt_last,
                   input ready);
   modport sink   (input valid, input fmt_char, input arg_value, input fmt_last,
                   output ready);
endinterface

// output character channel
interface pff_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_char;
   logic        status;
   logic        run_last;
   logic        format_done;
   logic [15:0] out_length;

   modport source (output valid, output out_char, output status, output run_last,
                   output format_done, output out_length, input ready);
   modport sink   (input valid, input out_char, input status, input run_last,
                   input format_done, input out_length, output ready);
endinterface

>>> sv/pff_ctrl.sv
`timescale 1ns / 1ps

module pff_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pff_pkg::stat_type  stat,
   output pff_pkg::cmd_type   cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_DABBLE = 5'b00100,
      ST_GEN    = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            unique case (stat.kind)
               pff_pkg::KIND_NONE:  state_in = ST_IDLE;
               pff_pkg::KIND_CHAR:  state_in = ST_EMIT;
               pff_pkg::KIND_ERROR: state_in = ST_EMIT;
               pff_pkg::KIND_NUM:   state_in = stat.is_dec ? ST_DABBLE : ST_GEN;
               default:             state_in = ST_IDLE;
            endcase
         end
         ST_DABBLE: begin
            cmd.dabble = 1'b1;
            if (stat.dabble_last) state_in = ST_GEN;
         end
         ST_GEN: begin
            cmd.gen = 1'b1;
            if (stat.gen_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = stat.out_free;
            if (stat.out_free && stat.emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // a byte with no output goes straight back for the next one
   a_none_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE && stat.kind == pff_pkg::KIND_NONE) |=> state_ff == ST_IDLE)
      else $error("byte without output did not return to idle");

   // a character is only pushed when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("character pushed into a full output register");

endmodule

>>> sv/pff_datapath.sv
`timescale 1ns / 1ps

module pff_datapath #(
   parameter int DIGIT_SLOTS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  pff_pkg::cmd_type  cmd,
   output pff_pkg::stat_type stat,
   input  logic [7:0]        in_fmt_char,
   input  logic [63:0]       in_arg_value,
   input  logic              in_fmt_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_status,
   output logic              rsp_run_last,
   output logic              rsp_format_done,
   output logic [15:0]       rsp_out_length
);

   localparam int IDX_W = $clog2(DIGIT_SLOTS);
   localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);

   // latched input word
   logic [7:0]  char_ff;
   logic [63:0] arg_ff;
   logic        last_ff;

   // specifier state
   logic [1:0]  phase_ff, phase_in;
   logic        wide_ff, wide_in;
   logic [15:0] len_ff, len_in;

   // pending prefix characters and error flag
   logic        err_ff;
   logic [7:0]  pre0_ff, pre1_ff;
   logic [1:0]  pre_cnt_ff;

   // digit generation
   logic [63:0]             bin_ff;
   logic [pff_pkg::BCD_W-1:0] work_ff;
   logic [pff_pkg::DAB_CNT_W-1:0] dab_cnt_ff;
   logic                    oct_ff;
   logic [CNT_W-1:0]        n_ff;
   logic [3:0]              store_ff [DIGIT_SLOTS];

   // output register
   logic        valid_ff;
   logic [7:0]  ochar_ff;
   logic        ostatus_ff, orun_ff, odone_ff;
   logic [15:0] olen_ff;

   // decode results
   pff_pkg::kind_type kind_d;
   logic        dec_d, oct_d;
   logic [7:0]  pre0_d, pre1_d;
   logic [1:0]  pre_cnt_d;
   logic [63:0] val_d, sval_d, arg32_d;

   // byte decode against the specifier state
   always_comb begin
      kind_d    = pff_pkg::KIND_NONE;
      dec_d     = 1'b0;
      oct_d     = 1'b0;
      pre0_d    = char_ff;
      pre1_d    = pff_pkg::CH_X_LOWER;
      pre_cnt_d = 2'd0;
      arg32_d   = {32'b0, arg_ff[31:0]};
      sval_d    = wide_ff ? arg_ff : {{32{arg_ff[31]}}, arg_ff[31:0]};
      val_d     = wide_ff ? arg_ff : arg32_d;
      phase_in  = phase_ff;
      wide_in   = wide_ff;
      if (phase_ff == 2'd0) begin
         if (char_ff == pff_pkg::CH_PERCENT) begin
            if (last_ff) kind_d = pff_pkg::KIND_ERROR;
            else begin
               phase_in = 2'd1;
               wide_in  = 1'b0;
            end
         end else begin
            kind_d    = pff_pkg::KIND_CHAR;
            pre_cnt_d = 2'd1;
         end
      end else if (char_ff == pff_pkg::CH_LONG && phase_ff != 2'd3) begin
         if (last_ff) kind_d = pff_pkg::KIND_ERROR;
         else begin
            phase_in = phase_ff + 2'd1;
            wide_in  = 1'b1;
         end
      end else begin
         unique case (char_ff)
            pff_pkg::CH_PERCENT: begin
               kind_d    = wide_ff ? pff_pkg::KIND_ERROR : pff_pkg::KIND_CHAR;
               pre_cnt_d = 2'd1;
            end
            pff_pkg::CH_CHAR: begin
               kind_d    = wide_ff ? pff_pkg::KIND_ERROR : pff_pkg::KIND_CHAR;
               pre0_d    = arg_ff[7:0];
               pre_cnt_d = 2'd1;
            end
            pff_pkg::CH_X_LOWER, pff_pkg::CH_X_UPPER: begin
               kind_d = pff_pkg::KIND_NUM;
            end
            pff_pkg::CH_DEC_D, pff_pkg::CH_DEC_I: begin
               kind_d = pff_pkg::KIND_NUM;
               dec_d  = 1'b1;
               val_d  = sval_d;
               if (sval_d[63]) begin
                  pre0_d    = pff_pkg::CH_MINUS;
                  pre_cnt_d = 2'd1;
                  val_d     = ~sval_d + 64'd1;
               end
            end
            pff_pkg::CH_UNS: begin
               kind_d = pff_pkg::KIND_NUM;
               dec_d  = 1'b1;
            end
            pff_pkg::CH_OCT: begin
               kind_d = pff_pkg::KIND_NUM;
               oct_d  = 1'b1;
            end
            pff_pkg::CH_PTR: begin
               kind_d    = pff_pkg::KIND_NUM;
               pre0_d    = pff_pkg::CH_ZERO;
               pre_cnt_d = 2'd2;
               val_d     = arg_ff;
            end
            default: kind_d = pff_pkg::KIND_ERROR;
         endcase
         phase_in = 2'd0;
         wide_in  = 1'b0;
      end
      // an error or the end of the format returns to the literal phase
      if (kind_d == pff_pkg::KIND_ERROR || (kind_d != pff_pkg::KIND_NONE && last_ff)) begin
         phase_in = 2'd0;
         wide_in  = 1'b0;
      end
   end

   // double dabble adjust: each bcd digit of five or more gets three added
   logic [pff_pkg::BCD_W-1:0] adj_d;
   logic [3:0] nib_d;
   always_comb begin
      adj_d = work_ff;
      nib_d = '0;
      for (int i = 0; i < pff_pkg::BCD_DIGITS; i++) begin
         nib_d = work_ff[4*i +: 4];
         adj_d[4*i +: 4] = (nib_d >= 4'd5) ? nib_d + 4'd3 : nib_d;
      end
   end

   // one digit off the low end per cycle
   logic [3:0]                gen_digit;
   logic [pff_pkg::BCD_W-1:0] gen_work;
   logic [CNT_W-1:0]          n_inc;
   always_comb begin
      gen_digit = oct_ff ? {1'b0, work_ff[2:0]} : work_ff[3:0];
      gen_work  = oct_ff ? (work_ff >> 3) : (work_ff >> 4);
      n_inc     = n_ff + CNT_W'(1);
   end

   // emission of the next character
   logic [CNT_W-1:0] rd_cnt;
   logic [IDX_W-1:0] rd_idx;
   logic [7:0]       emit_char;
   logic             emit_last, emit_done;
   logic [15:0]      len_inc;
   always_comb begin
      rd_cnt    = n_ff - CNT_W'(1);
      rd_idx    = rd_cnt[IDX_W-1:0];
      emit_char = err_ff ? 8'h00 :
                  (pre_cnt_ff != 2'd0) ? pre0_ff : pff_pkg::DIGIT_CHARS[store_ff[rd_idx]];
      emit_last = err_ff || (pre_cnt_ff == 2'd1 && n_ff == '0)
                         || (pre_cnt_ff == 2'd0 && n_ff == CNT_W'(1));
      emit_done = err_ff || (emit_last && last_ff);
      len_inc   = (len_ff == pff_pkg::LEN_MAX) ? len_ff : len_ff + 16'd1;
      len_in    = len_ff;
      if (cmd.emit) begin
         if (emit_done)    len_in = '0;
         else if (!err_ff) len_in = len_inc;
      end
   end

   // status to the controller
   always_comb begin
      stat.kind        = kind_d;
      stat.is_dec      = dec_d;
      stat.dabble_last = dab_cnt_ff == pff_pkg::DAB_CNT_W'(pff_pkg::ARG_W - 1);
      stat.gen_last    = (gen_work == '0) || (n_inc == CNT_W'(DIGIT_SLOTS));
      stat.emit_last   = emit_last;
      stat.out_free    = !valid_ff || rsp_ready;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 2'd0;
         wide_ff    <= 1'b0;
         len_ff     <= '0;
         err_ff     <= 1'b0;
         pre_cnt_ff <= 2'd0;
         n_ff       <= '0;
         valid_ff   <= 1'b0;
      end else begin
         len_ff <= len_in;
         if (cmd.decode) begin
            phase_ff   <= phase_in;
            wide_ff    <= wide_in;
            err_ff     <= kind_d == pff_pkg::KIND_ERROR;
            pre_cnt_ff <= (kind_d == pff_pkg::KIND_ERROR) ? 2'd0 : pre_cnt_d;
            n_ff       <= '0;
         end else if (cmd.gen) begin
            n_ff <= n_inc;
         end else if (cmd.emit) begin
            err_ff <= 1'b0;
            if (pre_cnt_ff != 2'd0) pre_cnt_ff <= pre_cnt_ff - 2'd1;
            else if (!err_ff)       n_ff <= rd_cnt;
         end
         if (cmd.emit)       valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         char_ff <= in_fmt_char;
         arg_ff  <= in_arg_value;
         last_ff <= in_fmt_last;
      end
      if (cmd.decode) begin
         pre0_ff    <= pre0_d;
         pre1_ff    <= pre1_d;
         oct_ff     <= oct_d;
         dab_cnt_ff <= '0;
         bin_ff     <= val_d;
         work_ff    <= dec_d ? '0 : {{(pff_pkg::BCD_W - 64){1'b0}}, val_d};
      end else if (cmd.dabble) begin
         work_ff    <= {adj_d[pff_pkg::BCD_W-2:0], bin_ff[63]};
         bin_ff     <= {bin_ff[62:0], 1'b0};
         dab_cnt_ff <= dab_cnt_ff + pff_pkg::DAB_CNT_W'(1);
      end else if (cmd.gen) begin
         work_ff <= gen_work;
         store_ff[n_ff[IDX_W-1:0]] <= gen_digit;
      end else if (cmd.emit && pre_cnt_ff != 2'd0) begin
         pre0_ff <= pre1_ff;
      end
      if (cmd.emit) begin
         ochar_ff   <= emit_char;
         ostatus_ff <= err_ff;
         orun_ff    <= emit_last;
         odone_ff   <= emit_done;
         olen_ff    <= err_ff ? len_ff : len_inc;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_char    = ochar_ff;
   assign rsp_status      = ostatus_ff;
   assign rsp_run_last    = orun_ff;
   assign rsp_format_done = odone_ff;
   assign rsp_out_length  = olen_ff;

   // an error word always ends both the byte and the format
   a_err_ends: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && ostatus_ff) |-> (orun_ff && odone_ff))
      else $error("error word without end marks");

   // the digit store never fills past its depth
   a_gen_depth: assert property (@(posedge clock) disable iff (reset)
      cmd.gen |-> (n_ff < CNT_W'(DIGIT_SLOTS)))
      else $error("digit store overrun");

   // nothing is left pending once the last character of a byte goes out
   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && emit_last) |=> (n_ff == '0 && pre_cnt_ff == 2'd0 && !err_ff))
      else $error("characters left after the last one");

endmodule

>>> sv/printf_style_formatter.sv
`timescale 1ns / 1ps

// channel   dir   words                        payload
// req_chan  in    one per format byte          fmt_char, arg_value, fmt_last
// rsp_chan  out   0 to 22 per format byte      out_char, status, run_last,
//                                              format_done, out_length
//
// one byte at a time: it is taken and decoded, then for a number one digit is
// generated per cycle (hex and octal), after a binary-to-bcd conversion for
// decimal, then one character goes out per cycle while rsp_chan takes them.
// the character output is a register, so a stalled rsp_chan only holds the
// character sequence; no new byte is taken until the last word is loaded.
// reset (synchronous) clears the specifier state and the character count.

module printf_style_formatter #(
   parameter int DIGIT_SLOTS = 24
) (
   input  logic        clock,
   input  logic        reset,
   pff_req_if.sink     req_chan,
   pff_rsp_if.source   rsp_chan
);

   pff_pkg::cmd_type  cmd;
   pff_pkg::stat_type stat;

   pff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pff_datapath #(
      .DIGIT_SLOTS (DIGIT_SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .in_fmt_char     (req_chan.fmt_char),
      .in_arg_value    (req_chan.arg_value),
      .in_fmt_last     (req_chan.fmt_last),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_char    (rsp_chan.out_char),
      .rsp_status      (rsp_chan.status),
      .rsp_run_last    (rsp_chan.run_last),
      .rsp_format_done (rsp_chan.format_done),
      .rsp_out_length  (rsp_chan.out_length)
   );

endmodule
